/* rtl/dcd_pkg.sv */
// shared types and constants of the detection candidate decoder
`default_nettype none

package dcd_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 17;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SCORE_THRESHOLD   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALL_LABELS_MODE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CLASS_OFFSET_STEP = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CLASS_COUNT       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_COEFF_COUNT       = 3'd4;

	// register reset values
	localparam logic [16:0] RST_SCORE_THRESHOLD   = 17'd16384;
	localparam logic        RST_ALL_LABELS_MODE   = 1'b1;
	localparam logic [15:0] RST_CLASS_OFFSET_STEP = 16'd7680;
	localparam logic [8:0]  RST_CLASS_COUNT       = 9'd80;
	localparam logic [6:0]  RST_COEFF_COUNT       = 7'd32;

	// candidate handed from the row parser to the scoring pipeline
	typedef struct packed {
		logic [7:0]          label;
		logic signed [31:0]  class_val;
		logic signed [31:0]  objectness;
		logic signed [31:0]  center_x;
		logic signed [31:0]  center_y;
		logic signed [30:0]  half_w;
		logic signed [30:0]  half_h;
		logic [15:0]         row;
	} cand_t;

endpackage

`default_nettype wire

/* rtl/dcd_channels.sv */
// valid/ready channel interfaces for prediction values and candidates
`default_nettype none

interface dcd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               start_of_image;

	modport source (output valid, output value, output start_of_image, input ready);
	modport sink (input valid, input value, input start_of_image, output ready);
endinterface

interface dcd_out_if;
	logic               valid;
	logic               ready;
	logic signed [40:0] left_edge;
	logic signed [40:0] top_edge;
	logic signed [40:0] right_edge;
	logic signed [40:0] bottom_edge;
	logic [7:0]         label;
	logic signed [31:0] score;
	logic [15:0]        row_index;

	modport source (output valid, output left_edge, output top_edge, output right_edge,
		output bottom_edge, output label, output score, output row_index, input ready);
	modport sink (input valid, input left_edge, input top_edge, input right_edge,
		input bottom_edge, input label, input score, input row_index, output ready);
endinterface

`default_nettype wire

/* rtl/dcd_row_parser.sv */
// row position tracking, box capture and class candidate selection
`default_nettype none

module dcd_row_parser #(
	parameter int MAX_CLASSES = 256,
	parameter int MAX_COEFFS  = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                take,
	input  wire signed [31:0]  value,
	input  wire                start_of_image,
	input  wire                all_labels_mode,
	input  wire [8:0]          class_count,
	input  wire [6:0]          coeff_count,
	output logic               cand_valid,
	output dcd_pkg::cand_t     cand
);

	localparam logic [8:0] POS_CX     = 9'd0;
	localparam logic [8:0] POS_CY     = 9'd1;
	localparam logic [8:0] POS_W      = 9'd2;
	localparam logic [8:0] POS_H      = 9'd3;
	localparam logic [8:0] POS_OBJ    = 9'd4;
	localparam logic [8:0] CLASS_BASE = 9'd5;

	logic [8:0]         pos_q;
	logic [15:0]        row_q;
	logic signed [31:0] cx_q, cy_q, bw_q, bh_q, obj_q, best_q;
	logic [7:0]         best_lab_q;

	logic [8:0]  nc;
	logic [6:0]  nm;
	logic [9:0]  row_len;
	logic [8:0]  p;
	logic [15:0] row_now;
	logic        is_class;
	logic [8:0]  lab_wide;
	logic        is_last;
	logic        new_best;

	always_comb begin
		nc = class_count;
		if (class_count == 9'd0)
			nc = 9'd1;
		else if ({23'd0, class_count} > MAX_CLASSES)
			nc = 9'(MAX_CLASSES);
		nm = coeff_count;
		if ({25'd0, coeff_count} > MAX_COEFFS)
			nm = 7'(MAX_COEFFS);
		row_len = {1'b0, CLASS_BASE} + {1'b0, nc} + {3'd0, nm};
	end

	assign p        = start_of_image ? 9'd0 : pos_q;
	assign row_now  = start_of_image ? 16'd0 : row_q;
	assign is_class = (p >= CLASS_BASE) && ({1'b0, p} < {1'b0, CLASS_BASE} + {1'b0, nc});
	assign lab_wide = p - CLASS_BASE;
	assign is_last  = lab_wide == nc - 9'd1;
	assign new_best = (lab_wide == 9'd0) || (value > best_q);

	always_comb begin
		cand_valid        = is_class && (all_labels_mode || is_last);
		cand.label        = all_labels_mode ? lab_wide[7:0]
			: (new_best ? lab_wide[7:0] : best_lab_q);
		cand.class_val    = (all_labels_mode || new_best) ? value : best_q;
		cand.objectness   = obj_q;
		cand.center_x     = cx_q;
		cand.center_y     = cy_q;
		cand.half_w       = bw_q[31:1];
		cand.half_h       = bh_q[31:1];
		cand.row          = row_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			row_q      <= '0;
			cx_q       <= '0;
			cy_q       <= '0;
			bw_q       <= '0;
			bh_q       <= '0;
			obj_q      <= '0;
			best_q     <= '0;
			best_lab_q <= '0;
		end else if (take) begin
			unique case (p)
				POS_CX:  cx_q  <= value;
				POS_CY:  cy_q  <= value;
				POS_W:   bw_q  <= value;
				POS_H:   bh_q  <= value;
				POS_OBJ: obj_q <= value;
				default: begin
					if (is_class && new_best) begin
						best_q     <= value;
						best_lab_q <= lab_wide[7:0];
					end
				end
			endcase
			// past the row end also wraps, so a shortened row recovers
			if ({1'b0, p} + 10'd1 >= row_len) begin
				pos_q <= '0;
				if (row_now != 16'hffff)
					row_q <= row_now + 16'd1;
				else
					row_q <= row_now;
			end else begin
				pos_q <= p + 9'd1;
				row_q <= row_now;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/detection_candidate_decoder.sv */
// top level: configuration registers and the scoring and box pipeline
`default_nettype none

// Takes one prediction value per cycle and emits box candidates. Rows are
// cx, cy, w, h, objectness, class_count class scores and coeff_count skipped
// values. A class value that may give a candidate passes three register
// stages: capture, the 32x32 objectness product with the label offset
// product, then threshold test, score saturation and edge sums in the output
// register. The input accepts a value every cycle; it only holds off when the
// output register is full and stalled and the stages behind it are occupied.
module detection_candidate_decoder #(
	parameter int MAX_CLASSES = 256,
	parameter int MAX_COEFFS  = 64
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	dcd_in_if.sink                                in_ch,
	dcd_out_if.source                             out_ch,
	input  wire                                   cfg_we,
	input  wire [dcd_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  wire [dcd_pkg::CFG_DATA_W-1:0]         cfg_data
);

	logic [16:0] thr_q;
	logic        all_labels_q;
	logic [15:0] step_q;
	logic [8:0]  class_count_q;
	logic [6:0]  coeff_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= dcd_pkg::RST_SCORE_THRESHOLD;
			all_labels_q  <= dcd_pkg::RST_ALL_LABELS_MODE;
			step_q        <= dcd_pkg::RST_CLASS_OFFSET_STEP;
			class_count_q <= dcd_pkg::RST_CLASS_COUNT;
			coeff_count_q <= dcd_pkg::RST_COEFF_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dcd_pkg::REG_SCORE_THRESHOLD:   thr_q         <= cfg_data[16:0];
				dcd_pkg::REG_ALL_LABELS_MODE:   all_labels_q  <= cfg_data[0];
				dcd_pkg::REG_CLASS_OFFSET_STEP: step_q        <= cfg_data[15:0];
				dcd_pkg::REG_CLASS_COUNT:       class_count_q <= cfg_data[8:0];
				dcd_pkg::REG_COEFF_COUNT:       coeff_count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	logic           rdy1, rdy2, rdy3;
	logic           take;
	logic           cand_valid;
	dcd_pkg::cand_t cand;

	logic               v_s1, v_s2;
	dcd_pkg::cand_t     cand_s1, cand_s2;
	logic signed [63:0] prod_s2;
	logic [23:0]        off_s2;

	logic               out_v_q;
	logic signed [40:0] left_q, top_q, right_q, bottom_q;
	logic [7:0]         label_q;
	logic signed [31:0] score_q;
	logic [15:0]        row_idx_q;

	assign rdy3        = !out_v_q || out_ch.ready;
	assign rdy2        = !v_s2 || rdy3;
	assign rdy1        = !v_s1 || rdy2;
	assign in_ch.ready = rdy1;
	assign take        = in_ch.valid && rdy1;

	dcd_row_parser #(
		.MAX_CLASSES (MAX_CLASSES),
		.MAX_COEFFS  (MAX_COEFFS)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.value           (in_ch.value),
		.start_of_image  (in_ch.start_of_image),
		.all_labels_mode (all_labels_q),
		.class_count     (class_count_q),
		.coeff_count     (coeff_count_q),
		.cand_valid      (cand_valid),
		.cand            (cand)
	);

	// stage 1: capture the candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy1)
			v_s1 <= take && cand_valid;
	end

	always_ff @(posedge clk) begin
		if (take && cand_valid)
			cand_s1 <= cand;
	end

	// stage 2: confidence product and label offset product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			cand_s2 <= cand_s1;
			prod_s2 <= cand_s1.objectness * cand_s1.class_val;
			off_s2  <= cand_s1.label * step_q;
		end
	end

	// stage 3: threshold, saturation and edges
	logic signed [47:0] conf;
	logic               pass;
	logic signed [31:0] score_sat;
	logic signed [40:0] off41, cx41, cy41, hw41, hh41;

	always_comb begin
		conf = prod_s2[63:16];
		pass = conf > $signed({31'd0, thr_q});
		if (conf > 48'sh0000_7fff_ffff)
			score_sat = 32'sh7fff_ffff;
		else if (conf < -48'sh0000_8000_0000)
			score_sat = 32'sh8000_0000;
		else
			score_sat = conf[31:0];
		off41 = {1'b0, off_s2, 16'd0};
		cx41  = {{9{cand_s2.center_x[31]}}, cand_s2.center_x};
		cy41  = {{9{cand_s2.center_y[31]}}, cand_s2.center_y};
		hw41  = {{10{cand_s2.half_w[30]}}, cand_s2.half_w};
		hh41  = {{10{cand_s2.half_h[30]}}, cand_s2.half_h};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (rdy3)
			out_v_q <= v_s2 && pass;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			left_q    <= cx41 - hw41 + off41;
			top_q     <= cy41 - hh41 + off41;
			right_q   <= cx41 + hw41 + off41;
			bottom_q  <= cy41 + hh41 + off41;
			label_q   <= cand_s2.label;
			score_q   <= score_sat;
			row_idx_q <= cand_s2.row;
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.left_edge   = left_q;
	assign out_ch.top_edge    = top_q;
	assign out_ch.right_edge  = right_q;
	assign out_ch.bottom_edge = bottom_q;
	assign out_ch.label       = label_q;
	assign out_ch.score       = score_q;
	assign out_ch.row_index   = row_idx_q;

	// an emitted score always clears the threshold
	a_score_above_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> score_q > $signed({15'd0, thr_q}))
		else $error("candidate score not above threshold");

	// a stalled output freezes the product stage
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready && v_s2 |=> v_s2 && $stable(prod_s2))
		else $error("product stage moved under output stall");

	// an empty capture stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ch.ready)
		else $error("input held off with empty capture stage");

	// only candidate beats enter the pipeline
	a_s1_only_cands: assert property (@(posedge clk) disable iff (!arst_n)
		rdy1 && !(take && cand_valid) |=> !v_s1)
		else $error("capture stage filled without a candidate");

endmodule

`default_nettype wire
